@@ design/spimcs_pkg.sv @@
`timescale 1ns / 1ps

package spimcs_pkg;

	localparam logic [1:0] OP_SPI   = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_DONE  = 2'd2;
	localparam logic [1:0] OP_TABLE = 2'd3;

	localparam logic [7:0] CMD_START = 8'd13;
	localparam logic [7:0] CMD_LOAD  = 8'd17;
	localparam logic [7:0] CMD_STOP  = 8'd29;
	localparam logic [7:0] DIR_FWD   = 8'd5;
	localparam logic [7:0] DIR_BACK  = 8'd7;

	localparam logic [15:0] CW_RUN  = 16'h2068;
	localparam logic [15:0] CW_HALT = 16'h2148;

	localparam logic [7:0] RELOAD_LOW0 = 8'hFF;
	localparam logic [7:0] RELOAD_LOW1 = 8'hFA;

	localparam logic [2:0] SEND_LEFT_CTRL = 3'd2;
	localparam logic [2:0] SEND_LEFT_FREQ = 3'd4;

	typedef enum logic [2:0] {
		LOAD_IDLE       = 3'd0,
		LOAD_COUNT_HIGH = 3'd1,
		LOAD_COUNT_LOW1 = 3'd2,
		LOAD_COUNT_LOW0 = 3'd3,
		LOAD_FREQ       = 3'd4,
		LOAD_DIR        = 3'd5
	} load_phase_t;

	typedef enum logic [1:0] {
		SEND_NONE = 2'd0,
		SEND_CTRL = 2'd1,
		SEND_FREQ = 2'd2
	} send_kind_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  data_byte;
		logic [7:0]  table_index;
		logic [31:0] table_word;
	} cmd_word_t;

	typedef struct packed {
		logic       serial_valid;
		logic [7:0] serial_byte;
		logic       select_active;
		logic       reply_valid;
		logic       direction;
		logic       running;
	} rsp_word_t;

endpackage

@@ design/spimcs_freq_table.sv @@
`timescale 1ns / 1ps

module spimcs_freq_table #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [31:0]   wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [31:0]   rd_data
);

	logic [31:0] mem [DEPTH];
	logic [31:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// forward a write to the watched entry so the next read sees it
	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == rd_addr)) begin
			rd_data_q <= wr_data;
		end else begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ design/spimcs_skid.sv @@
`timescale 1ns / 1ps

module spimcs_skid (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  spimcs_pkg::rsp_word_t push_data,
	output logic                  full,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output spimcs_pkg::rsp_word_t rsp
);

	logic                  out_valid_q;
	logic                  skid_valid_q;
	spimcs_pkg::rsp_word_t out_q;
	spimcs_pkg::rsp_word_t skid_q;
	logic                  out_take;

	assign out_take = out_valid_q && !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || out_take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (!out_valid_q || out_take) begin
				out_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

	assign full      = skid_valid_q;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

@@ design/spi_motor_command_sequencer_unit.sv @@
`timescale 1ns / 1ps

// SPI motor command sequencer. Each accepted command word (SPI byte, capture
// tick, serial byte done or frequency table write) is handled in a single
// pass of logic between the state registers and the response register, so
// the response word is registered into the output register when it is free,
// and a new command can be taken every cycle while cmd_stall is low. A second
// response register lets one more command in while rsp_stall holds the
// output word; cmd_stall then stays high until that output word is taken.
// The frequency table holds TABLE_DEPTH words with one write port and a
// registered read port that tracks the selected entry, so the word fetched
// at the end of a parameter load is ready in time. Table entries must be
// written before a load selects them.
module spi_motor_command_sequencer_unit #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  spimcs_pkg::cmd_word_t cmd,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output spimcs_pkg::rsp_word_t rsp
);

	localparam int AW = $clog2(TABLE_DEPTH);

	logic accept;
	logic full;

	spimcs_pkg::load_phase_t phase_q, phase_d;
	spimcs_pkg::send_kind_t  kind_q, kind_d;
	logic [2:0]    left_q, left_d;
	logic          dir_q, dir_d;
	logic          run_q, run_d;
	logic          select_q, select_d;
	logic [AW-1:0] sel_addr_q, sel_addr_d;
	logic [7:0]    low0_q, low0_d;
	logic [7:0]    low1_q, low1_d;
	logic [7:0]    high_q, high_d;
	logic [31:0]   fword_q, fword_d;
	logic [15:0]   cw_q, cw_d;

	logic [AW-1:0] mod_lut [256];
	logic [31:0]   table_rd;
	logic          table_wr;

	logic          open_send;
	logic          send_byte;
	logic          reply;
	logic [7:0]    sbyte;
	spimcs_pkg::rsp_word_t res;

	for (genvar i = 0; i < 256; i++) begin : g_mod
		assign mod_lut[i] = AW'(i % TABLE_DEPTH);
	end

	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = full;
	assign table_wr  = accept && (cmd.op == spimcs_pkg::OP_TABLE);

	spimcs_freq_table #(
		.DEPTH(TABLE_DEPTH),
		.AW   (AW)
	) u_table (
		.clk    (clk),
		.wr_en  (table_wr),
		.wr_addr(mod_lut[cmd.table_index]),
		.wr_data(cmd.table_word),
		.rd_addr(sel_addr_q),
		.rd_data(table_rd)
	);

	always_comb begin
		open_send = 1'b0;
		send_byte = 1'b0;
		reply     = 1'b0;
		sbyte     = 8'h00;
		case (cmd.op)
			spimcs_pkg::OP_SPI: begin
				if (phase_q == spimcs_pkg::LOAD_IDLE) begin
					open_send = (cmd.data_byte == spimcs_pkg::CMD_STOP) ||
						(cmd.data_byte == spimcs_pkg::CMD_START);
				end else if (phase_q == spimcs_pkg::LOAD_COUNT_LOW1) begin
					reply = 1'b1;
				end else if (phase_q == spimcs_pkg::LOAD_COUNT_HIGH) begin
					open_send = 1'b1;
				end
			end
			spimcs_pkg::OP_TICK: begin
				open_send = run_q && (low0_q == 8'h00) && (low1_q == 8'h00) &&
					(high_q == 8'h00);
			end
			spimcs_pkg::OP_DONE: begin
				if (kind_q == spimcs_pkg::SEND_FREQ) begin
					send_byte = (left_q >= 3'd1) && (left_q <= 3'd4);
					case (left_q)
						3'd4:    sbyte = fword_q[15:8];
						3'd3:    sbyte = fword_q[7:0];
						3'd2:    sbyte = fword_q[31:24];
						3'd1:    sbyte = fword_q[23:16];
						default: sbyte = 8'h00;
					endcase
				end else if (kind_q == spimcs_pkg::SEND_CTRL) begin
					send_byte = (left_q == 3'd2) || (left_q == 3'd1);
					if (left_q == 3'd2) begin
						sbyte = cw_q[15:8];
					end else if (left_q == 3'd1) begin
						sbyte = cw_q[7:0];
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		phase_d    = phase_q;
		kind_d     = kind_q;
		left_d     = left_q;
		dir_d      = dir_q;
		run_d      = run_q;
		select_d   = select_q;
		sel_addr_d = sel_addr_q;
		low0_d     = low0_q;
		low1_d     = low1_q;
		high_d     = high_q;
		fword_d    = fword_q;
		cw_d       = cw_q;
		case (cmd.op)
			spimcs_pkg::OP_SPI: begin
				case (phase_q)
					spimcs_pkg::LOAD_IDLE: begin
						if (cmd.data_byte == spimcs_pkg::CMD_STOP) begin
							cw_d   = spimcs_pkg::CW_HALT;
							run_d  = 1'b0;
							kind_d = spimcs_pkg::SEND_CTRL;
							left_d = spimcs_pkg::SEND_LEFT_CTRL;
						end else if (cmd.data_byte == spimcs_pkg::CMD_START) begin
							cw_d   = spimcs_pkg::CW_RUN;
							run_d  = 1'b1;
							kind_d = spimcs_pkg::SEND_CTRL;
							left_d = spimcs_pkg::SEND_LEFT_CTRL;
						end else if (cmd.data_byte == spimcs_pkg::CMD_LOAD) begin
							phase_d = spimcs_pkg::LOAD_DIR;
						end
					end
					spimcs_pkg::LOAD_DIR: begin
						if (cmd.data_byte == spimcs_pkg::DIR_BACK) begin
							dir_d = 1'b1;
						end else if (cmd.data_byte == spimcs_pkg::DIR_FWD) begin
							dir_d = 1'b0;
						end
						phase_d = spimcs_pkg::LOAD_FREQ;
					end
					spimcs_pkg::LOAD_FREQ: begin
						sel_addr_d = mod_lut[cmd.data_byte];
						phase_d    = spimcs_pkg::LOAD_COUNT_LOW0;
					end
					spimcs_pkg::LOAD_COUNT_LOW0: begin
						low0_d  = cmd.data_byte;
						phase_d = spimcs_pkg::LOAD_COUNT_LOW1;
					end
					spimcs_pkg::LOAD_COUNT_LOW1: begin
						low1_d  = cmd.data_byte;
						phase_d = spimcs_pkg::LOAD_COUNT_HIGH;
					end
					spimcs_pkg::LOAD_COUNT_HIGH: begin
						high_d  = cmd.data_byte;
						phase_d = spimcs_pkg::LOAD_IDLE;
						fword_d = table_rd;
						kind_d  = spimcs_pkg::SEND_FREQ;
						left_d  = spimcs_pkg::SEND_LEFT_FREQ;
					end
					default: begin
						phase_d = spimcs_pkg::LOAD_IDLE;
					end
				endcase
			end
			spimcs_pkg::OP_TICK: begin
				if (run_q) begin
					if (low0_q != 8'h00) begin
						low0_d = low0_q - 8'd1;
					end else if (low1_q != 8'h00) begin
						low1_d = low1_q - 8'd1;
						low0_d = spimcs_pkg::RELOAD_LOW0;
					end else if (high_q != 8'h00) begin
						high_d = high_q - 8'd1;
						low1_d = spimcs_pkg::RELOAD_LOW1;
					end else begin
						cw_d   = spimcs_pkg::CW_HALT;
						run_d  = 1'b0;
						kind_d = spimcs_pkg::SEND_CTRL;
						left_d = spimcs_pkg::SEND_LEFT_CTRL;
					end
				end
			end
			spimcs_pkg::OP_DONE: begin
				if ((kind_q == spimcs_pkg::SEND_FREQ) || (kind_q == spimcs_pkg::SEND_CTRL)) begin
					if (send_byte) begin
						select_d = 1'b1;
						left_d   = left_q - 3'd1;
					end else begin
						select_d = 1'b0;
						kind_d   = spimcs_pkg::SEND_NONE;
						left_d   = 3'd0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= spimcs_pkg::LOAD_IDLE;
			kind_q     <= spimcs_pkg::SEND_NONE;
			left_q     <= 3'd0;
			dir_q      <= 1'b0;
			run_q      <= 1'b0;
			select_q   <= 1'b0;
			sel_addr_q <= '0;
			low0_q     <= 8'h00;
			low1_q     <= 8'h00;
			high_q     <= 8'h00;
			fword_q    <= 32'h0;
			cw_q       <= spimcs_pkg::CW_HALT;
		end else if (accept) begin
			phase_q    <= phase_d;
			kind_q     <= kind_d;
			left_q     <= left_d;
			dir_q      <= dir_d;
			run_q      <= run_d;
			select_q   <= select_d;
			sel_addr_q <= sel_addr_d;
			low0_q     <= low0_d;
			low1_q     <= low1_d;
			high_q     <= high_d;
			fword_q    <= fword_d;
			cw_q       <= cw_d;
		end
	end

	assign res.serial_valid  = open_send || send_byte;
	assign res.serial_byte   = send_byte ? sbyte : 8'h00;
	assign res.select_active = select_d;
	assign res.reply_valid   = reply;
	assign res.direction     = dir_d;
	assign res.running       = run_d;

	spimcs_skid u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_data(res),
		.full     (full),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

`ifndef SYNTH
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> rsp_valid)
		else $error("response buffer holds a word with the output empty");

	a_run_needs_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd_valid && !cmd_stall) |=> $stable(run_q) && $stable(kind_q))
		else $error("state changed without an accepted command");

	a_idle_send_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(kind_q == spimcs_pkg::SEND_NONE) |-> (left_q == 3'd0))
		else $error("send count left over with nothing to send");

	a_reply_in_load: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && reply) |=> (phase_q == spimcs_pkg::LOAD_COUNT_HIGH))
		else $error("reply raised outside the count load");
`endif

endmodule
